### rtl/rmq_pkg.sv
`default_nettype none
package rmq_pkg;

    // case_taken codes
    localparam logic [1:0] CASE_TRACE = 2'd0;
    localparam logic [1:0] CASE_X     = 2'd1;
    localparam logic [1:0] CASE_Y     = 2'd2;
    localparam logic [1:0] CASE_Z     = 2'd3;

    localparam int unsigned N_ELEM  = 9;
    localparam int unsigned N_LANE  = 3;
    localparam int unsigned CASE_W  = 2;

endpackage
`default_nettype wire

### rtl/rotation_matrix_to_quaternion.sv
// channel | dir | tdata fields (low bit up)                      | other
// s_      | in  | m00 m01 m02 m10 m11 m12 m20 m21 m22, zero pad  | tvalid tready
// m_      | out | quat_x quat_y quat_z quat_w case_taken, pad   | tvalid tready
// One word per cycle while the output is not stalled. Stages: three setup stages, one
// root bit per stage, one quotient bit per stage in three lanes, output register.
// aresetn clears the valid bits only. A stalled output word freezes the whole pipe.
`default_nettype none
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 28
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // m00 m01 m02 m10 m11 m12 m20 m21 m22
    input  wire logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // quat_x quat_y quat_z quat_w case_taken
    output logic [((4*DATA_WIDTH+2+7)/8)*8-1:0] m_tdata
);
    localparam int DW  = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int NW  = DW + 1;
    localparam int CW  = ((DW > F) ? DW : F) + 3;
    localparam int RW  = CW - 1 + F;
    localparam int SW  = (RW + 1) / 2;
    localparam int ND  = NW + F;
    localparam int HW  = ((SW > DW) ? SW : DW) + 1;
    localparam int OTW = ((4*DW+2+7)/8)*8;
    localparam int CSW = rmq_pkg::CASE_W;
    localparam logic [CW-1:0] ONE_C = {{(CW-1){1'b0}}, 1'b1} << F;
    localparam logic [HW-1:0] MAXP  = {{(HW-DW+1){1'b0}}, {(DW-1){1'b1}}};

    logic en;
    logic m_valid_reg;
    logic [OTW-1:0] m_data_reg;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // stage 1: capture
    logic p1_valid_reg;
    logic signed [DW-1:0] p1_m_reg [0:8];
    always_ff @(posedge aclk) begin
        if (!aresetn) p1_valid_reg <= 1'b0;
        else if (en) p1_valid_reg <= s_tvalid;
    end
    for (genvar e = 0; e < 9; e++) begin : g_cap
        always_ff @(posedge aclk) begin
            if (en) p1_m_reg[e] <= s_tdata[e*DW +: DW];
        end
    end

    // stage 2: trace, largest diagonal, sums and differences
    logic p2_valid_reg;
    logic p2_pos_reg;
    logic [1:0] p2_idx_reg;
    logic signed [CW-1:0] p2_tr_reg;
    logic signed [CW-1:0] p2_dg_reg [0:2];
    logic signed [NW-1:0] p2_d12_reg, p2_d20_reg, p2_d01_reg;
    logic signed [NW-1:0] p2_a01_reg, p2_a02_reg, p2_a12_reg;
    logic signed [CW-1:0] tr_c;
    logic [1:0] idx_c;
    always_comb begin
        tr_c = CW'(p1_m_reg[0]) + CW'(p1_m_reg[4]) + CW'(p1_m_reg[8]);
        idx_c = 2'd0;
        if (p1_m_reg[4] > p1_m_reg[0]) idx_c = 2'd1;
        if (p1_m_reg[8] > ((idx_c == 2'd1) ? p1_m_reg[4] : p1_m_reg[0])) idx_c = 2'd2;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) p2_valid_reg <= 1'b0;
        else if (en) p2_valid_reg <= p1_valid_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            p2_pos_reg <= tr_c > 0;
            p2_idx_reg <= idx_c;
            p2_tr_reg  <= tr_c;
            p2_dg_reg[0] <= CW'(p1_m_reg[0]);
            p2_dg_reg[1] <= CW'(p1_m_reg[4]);
            p2_dg_reg[2] <= CW'(p1_m_reg[8]);
            p2_d12_reg <= NW'(p1_m_reg[5]) - NW'(p1_m_reg[7]);
            p2_d20_reg <= NW'(p1_m_reg[6]) - NW'(p1_m_reg[2]);
            p2_d01_reg <= NW'(p1_m_reg[1]) - NW'(p1_m_reg[3]);
            p2_a01_reg <= NW'(p1_m_reg[1]) + NW'(p1_m_reg[3]);
            p2_a02_reg <= NW'(p1_m_reg[2]) + NW'(p1_m_reg[6]);
            p2_a12_reg <= NW'(p1_m_reg[5]) + NW'(p1_m_reg[7]);
        end
    end

    // stage 3: root argument, lane numerators
    logic signed [CW-1:0] arg_c;
    logic [CSW-1:0] case_c;
    logic signed [NW-1:0] num_c [0:2];
    always_comb begin
        case (p2_idx_reg)
            2'd1: begin
                arg_c = p2_dg_reg[1] - p2_dg_reg[2] - p2_dg_reg[0] + ONE_C;
                num_c[0] = p2_a01_reg; num_c[1] = p2_d20_reg; num_c[2] = p2_a12_reg;
                case_c = rmq_pkg::CASE_Y;
            end
            2'd2: begin
                arg_c = p2_dg_reg[2] - p2_dg_reg[0] - p2_dg_reg[1] + ONE_C;
                num_c[0] = p2_a02_reg; num_c[1] = p2_a12_reg; num_c[2] = p2_d01_reg;
                case_c = rmq_pkg::CASE_Z;
            end
            default: begin
                arg_c = p2_dg_reg[0] - p2_dg_reg[1] - p2_dg_reg[2] + ONE_C;
                num_c[0] = p2_d12_reg; num_c[1] = p2_a01_reg; num_c[2] = p2_a02_reg;
                case_c = rmq_pkg::CASE_X;
            end
        endcase
        if (p2_pos_reg) begin
            arg_c = p2_tr_reg + ONE_C;
            num_c[0] = p2_d12_reg; num_c[1] = p2_d20_reg; num_c[2] = p2_d01_reg;
            case_c = rmq_pkg::CASE_TRACE;
        end
    end

    // root stages: index 0 is the stage-3 register
    logic               sq_valid_reg [0:SW];
    logic [SW+1:0]      sq_rem_reg   [0:SW];
    logic [SW-1:0]      sq_root_reg  [0:SW];
    logic [2*SW-1:0]    sq_rad_reg   [0:SW];
    logic [CSW-1:0]     sq_case_reg  [0:SW];
    logic               sq_neg_reg   [0:SW][0:2];
    logic [NW-1:0]      sq_mag_reg   [0:SW][0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) sq_valid_reg[0] <= 1'b0;
        else if (en) sq_valid_reg[0] <= p2_valid_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_rad_reg[0]  <= (2*SW)'({((arg_c < 0) ? {(CW-1){1'b0}} : arg_c[CW-2:0]),
                                       {F{1'b0}}});
            sq_case_reg[0] <= case_c;
        end
    end
    for (genvar l = 0; l < 3; l++) begin : g_mag
        always_ff @(posedge aclk) begin
            if (en) begin
                sq_neg_reg[0][l] <= num_c[l][NW-1];
                sq_mag_reg[0][l] <= num_c[l][NW-1] ? NW'(-num_c[l]) : num_c[l];
            end
        end
    end

    for (genvar t = 0; t < SW; t++) begin : g_sqrt
        logic [SW+1:0] rsh, trial;
        logic          take;
        always_comb begin
            rsh   = {sq_rem_reg[t][SW-1:0], sq_rad_reg[t][2*SW-1 -: 2]};
            trial = {sq_root_reg[t], 2'b01};
            take  = rsh >= trial;
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) sq_valid_reg[t+1] <= 1'b0;
            else if (en) sq_valid_reg[t+1] <= sq_valid_reg[t];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                sq_rem_reg[t+1]  <= take ? rsh - trial : rsh;
                sq_root_reg[t+1] <= {sq_root_reg[t][SW-2:0], take};
                sq_rad_reg[t+1]  <= sq_rad_reg[t] << 2;
                sq_case_reg[t+1] <= sq_case_reg[t];
                sq_neg_reg[t+1]  <= sq_neg_reg[t];
                sq_mag_reg[t+1]  <= sq_mag_reg[t];
            end
        end
    end

    // divide stages: one quotient bit per stage in each lane
    logic               dv_valid [0:ND];
    logic [SW:0]        dv_d     [0:ND];
    logic [SW-1:0]      dv_root  [0:ND];
    logic [CSW-1:0]     dv_case  [0:ND];
    logic               dv_neg   [0:ND][0:2];
    logic [NW-1:0]      dv_mag   [0:ND][0:2];
    logic [SW:0]        dv_r     [0:ND][0:2];
    logic [DW:0]        dv_q     [0:ND][0:2];
    logic               dv_ovf   [0:ND][0:2];

    assign dv_valid[0] = sq_valid_reg[SW];
    assign dv_d[0]     = {sq_root_reg[SW], 1'b0};
    assign dv_root[0]  = sq_root_reg[SW];
    assign dv_case[0]  = sq_case_reg[SW];
    for (genvar l = 0; l < 3; l++) begin : g_dv0
        assign dv_neg[0][l] = sq_neg_reg[SW][l];
        assign dv_mag[0][l] = sq_mag_reg[SW][l];
        assign dv_r[0][l]   = '0;
        assign dv_q[0][l]   = '0;
        assign dv_ovf[0][l] = 1'b0;
    end

    for (genvar t = 0; t < ND; t++) begin : g_div
        always_ff @(posedge aclk) begin
            if (!aresetn) dv_valid[t+1] <= 1'b0;
            else if (en) dv_valid[t+1] <= dv_valid[t];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                dv_d[t+1]    <= dv_d[t];
                dv_root[t+1] <= dv_root[t];
                dv_case[t+1] <= dv_case[t];
            end
        end
        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [SW+1:0] rsh;
            logic          take;
            always_comb begin
                rsh  = {dv_r[t][l], dv_mag[t][l][NW-1]};
                take = rsh >= {1'b0, dv_d[t]};
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    dv_neg[t+1][l] <= dv_neg[t][l];
                    dv_mag[t+1][l] <= dv_mag[t][l] << 1;
                    dv_r[t+1][l]   <= take ? (SW+1)'(rsh - {1'b0, dv_d[t]}) : rsh[SW:0];
                    dv_q[t+1][l]   <= {dv_q[t][l][DW-1:0], take};
                    dv_ovf[t+1][l] <= dv_ovf[t][l] | dv_q[t][l][DW];
                end
            end
        end
    end

    // saturate and route
    logic [DW-1:0] lane_c [0:2];
    logic [DW-1:0] half_c;
    logic [HW-1:0] half_w;
    logic [DW-1:0] qx_c, qy_c, qz_c, qw_c;
    for (genvar l = 0; l < 3; l++) begin : g_sat
        logic big;
        always_comb begin
            big = dv_ovf[ND][l] || dv_q[ND][l][DW]
                || (HW'(dv_q[ND][l]) > (dv_neg[ND][l] ? MAXP + 1'b1 : MAXP));
            if (dv_d[ND] == '0)
                lane_c[l] = '0;
            else if (big)
                lane_c[l] = dv_neg[ND][l] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
            else
                lane_c[l] = dv_neg[ND][l] ? DW'(-dv_q[ND][l]) : dv_q[ND][l][DW-1:0];
        end
    end
    always_comb begin
        half_w = HW'(dv_root[ND] >> 1);
        half_c = (half_w > MAXP) ? MAXP[DW-1:0] : half_w[DW-1:0];
        qx_c = (dv_case[ND] == rmq_pkg::CASE_X) ? half_c : lane_c[0];
        qy_c = (dv_case[ND] == rmq_pkg::CASE_Y) ? half_c : lane_c[1];
        qz_c = (dv_case[ND] == rmq_pkg::CASE_Z) ? half_c : lane_c[2];
        case (dv_case[ND])
            rmq_pkg::CASE_X: qw_c = lane_c[0];
            rmq_pkg::CASE_Y: qw_c = lane_c[1];
            rmq_pkg::CASE_Z: qw_c = lane_c[2];
            default:         qw_c = half_c;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (en) m_valid_reg <= dv_valid[ND];
    end
    always_ff @(posedge aclk) begin
        if (en) m_data_reg <= OTW'({dv_case[ND], qw_c, qz_c, qy_c, qx_c});
    end

endmodule
`default_nettype wire

### rtl/rmq_checker.sv
`default_nettype none
module rmq_checker #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [((4*DATA_WIDTH+2+7)/8)*8-1:0] m_tdata
);
    localparam int DW = DATA_WIDTH;

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output word valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_w_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4*DW+1:4*DW] == rmq_pkg::CASE_TRACE |-> !m_tdata[4*DW-1])
        else $error("negative w on positive trace");

    a_x_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4*DW+1:4*DW] == rmq_pkg::CASE_X |-> !m_tdata[DW-1])
        else $error("negative x when x was largest");

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rmq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

### tb/sv/rotation_matrix_to_quaternion_chk.sv
`default_nettype none
module rotation_matrix_to_quaternion_chk #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 28
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [287:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [135:0] m_tdata,
    output int                fails,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [rmq_pkg::CASE_W-1:0] ct;
        logic [DATA_WIDTH-1:0] w;
        logic [DATA_WIDTH-1:0] z;
        logic [DATA_WIDTH-1:0] y;
        logic [DATA_WIDTH-1:0] x;
    } quat_t;

    quat_t expected_quats[$];

    localparam longint ONE  = longint'(1) << FRAC_BITS;
    localparam longint QMAX = (longint'(1) << (DATA_WIDTH - 1)) - 1;
    localparam longint QMIN = -QMAX - 1;

    function automatic longint clamp_q(longint v);
        if (v > QMAX) return QMAX;
        if (v < QMIN) return QMIN;
        return v;
    endfunction

    // floor(sqrt(a * 2^FRAC_BITS))
    function automatic longint root_scaled(longint a);
        longint unsigned v, r, t;
        v = longint'(a) << FRAC_BITS;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v) r = t;
        end
        return longint'(r);
    endfunction

    // num / (2s) in fixed point, truncated toward zero
    function automatic longint div_2s(longint num, longint s);
        longint mag, q;
        if (s == 0) return 0;
        mag = (num < 0) ? -num : num;
        q = (mag << FRAC_BITS) / (2 * s);
        return clamp_q((num < 0) ? -q : q);
    endfunction

    function automatic quat_t shoemake_quat(logic [287:0] d);
        longint m[3][3];
        longint q[4];
        longint tr, arg, s;
        int i, j, k;
        quat_t r;
        for (int a = 0; a < 3; a++)
            for (int c = 0; c < 3; c++)
                m[a][c] = longint'($signed(d[DATA_WIDTH*(a*3+c) +: DATA_WIDTH]));
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0) begin
            s = root_scaled(tr + ONE);
            q[3] = clamp_q(s >>> 1);
            q[0] = div_2s(m[1][2] - m[2][1], s);
            q[1] = div_2s(m[2][0] - m[0][2], s);
            q[2] = div_2s(m[0][1] - m[1][0], s);
            r.ct = rmq_pkg::CASE_TRACE;
        end else begin
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i == 2) ? 0 : i + 1;
            k = (j == 2) ? 0 : j + 1;
            arg = m[i][i] - (m[j][j] + m[k][k]) + ONE;
            if (arg < 0) arg = 0;
            s = root_scaled(arg);
            q[i] = clamp_q(s >>> 1);
            q[3] = div_2s(m[j][k] - m[k][j], s);
            q[j] = div_2s(m[i][j] + m[j][i], s);
            q[k] = div_2s(m[i][k] + m[k][i], s);
            case (i)
                0: r.ct = rmq_pkg::CASE_X;
                1: r.ct = rmq_pkg::CASE_Y;
                default: r.ct = rmq_pkg::CASE_Z;
            endcase
        end
        r.x = q[0][DATA_WIDTH-1:0];
        r.y = q[1][DATA_WIDTH-1:0];
        r.z = q[2][DATA_WIDTH-1:0];
        r.w = q[3][DATA_WIDTH-1:0];
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        fails++;
    endtask

    initial begin
        fails = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        quat_t got, want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_quats.push_back(shoemake_quat(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata[4*DATA_WIDTH+rmq_pkg::CASE_W-1:0];
                if (expected_quats.size() == 0) begin
                    report("unexpected word", 64'(got.x), 64'(0));
                end else begin
                    want = expected_quats.pop_front();
                    if (got.x !== want.x) report("quat_x", 64'(got.x), 64'(want.x));
                    if (got.y !== want.y) report("quat_y", 64'(got.y), 64'(want.y));
                    if (got.z !== want.z) report("quat_z", 64'(got.z), 64'(want.z));
                    if (got.w !== want.w) report("quat_w", 64'(got.w), 64'(want.w));
                    if (got.ct !== want.ct) report("case_taken", 64'(got.ct), 64'(want.ct));
                end
            end
            pending = expected_quats.size();
        end
    end

endmodule
`default_nettype wire

### tb/sv/rotation_matrix_to_quaternion_tb.sv
`default_nettype none
module rotation_matrix_to_quaternion_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     DW  = 32;
    localparam longint ONE = longint'(1) << 28;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [287:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    int           fails;
    int           pending;

    always #4 aclk = ~aclk;

    rotation_matrix_to_quaternion #(.DATA_WIDTH(32), .FRAC_BITS(28)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    rotation_matrix_to_quaternion_chk #(.DATA_WIDTH(32), .FRAC_BITS(28)) chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fails(fails), .pending(pending)
    );

    typedef logic [31:0] mat_t[9];

    function automatic logic [287:0] pack_mat(mat_t e);
        logic [287:0] d;
        for (int n = 0; n < 9; n++) d[32*n +: 32] = e[n];
        return d;
    endfunction

    int burst_left = 0;

    task automatic send_matrix(mat_t e);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tdata = pack_mat(e);
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(ONE);
            3: return 32'(-ONE);
            4: return 32'h0;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    function automatic mat_t random_matrix();
        mat_t e;
        int   dom;
        int   mode;
        mode = $urandom_range(0, 9);
        dom = $urandom_range(0, 2);
        for (int n = 0; n < 9; n++) begin
            if (mode < 3)
                e[n] = $urandom;
            else if (mode < 8)
                e[n] = 32'(longint'($urandom_range(0, 2 * ONE)) - ONE);
            else
                e[n] = pick_extreme();
        end
        // diagonal-led matrices with a non-positive trace reach the x/y/z branches
        if (mode >= 5 && mode < 8) begin
            for (int a = 0; a < 3; a++)
                e[4*a] = 32'(-longint'($urandom_range(0, ONE)));
            e[4*dom] = 32'($urandom_range(0, ONE / 2));
            if ($urandom_range(0, 4) == 0) e[4*((dom + 1) % 3)] = e[4*dom];
        end
        return e;
    endfunction

    always @(negedge aclk) begin
        case ($urandom_range(0, 3))
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 1) != 0);
            default: m_tready <= ($urandom_range(0, 7) == 0) ? 1'b0 : m_tready;
        endcase
    end

    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        mat_t e;
        logic [31:0] o, no, z;
        o = 32'(ONE);
        no = 32'(-ONE);
        z = 32'h0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        e = '{o, z, z, z, o, z, z, z, o};                  send_matrix(e);
        e = '{z, z, z, z, z, z, z, z, z};                  send_matrix(e);
        e = '{no, z, z, z, no, z, z, z, no};               send_matrix(e);
        e = '{o, z, z, z, no, z, z, z, no};                send_matrix(e);
        e = '{no, z, z, z, o, z, z, z, no};                send_matrix(e);
        e = '{no, z, z, z, no, z, z, z, o};                send_matrix(e);
        e = '{z, o, z, no, z, z, z, z, z};                 send_matrix(e);
        e = '{o, z, z, z, o, z, z, z, no};                 send_matrix(e);
        e = '{no, o, o, o, no, o, o, o, no};               send_matrix(e);
        e = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff}; send_matrix(e);
        e = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000}; send_matrix(e);
        e = '{32'h8000_0000, z, z, z, 32'h7fff_ffff, z, z, z, 32'h7fff_ffff};   send_matrix(e);
        e = '{32'hc000_0000, 32'h7fff_ffff, z, 32'h8000_0000, 32'hc000_0000,
              z, z, z, 32'hc000_0000};                     send_matrix(e);
        e = '{z, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000}; send_matrix(e);
        e = '{32'h0000_0001, z, z, z, 32'hffff_ffff, z, z, z, z};       send_matrix(e);
        e = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff}; send_matrix(e);

        for (int n = 0; n < 1400; n++) begin
            if (n == 700) begin
                s_tvalid = 1'b0;
                wait (pending == 0);
                @(negedge aclk);
            end
            send_matrix(random_matrix());
        end
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (200) @(negedge aclk);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
